>>> rtl/tbpa_pkg.sv
`default_nettype none
package tbpa_pkg;

    localparam int MEM_BYTES  = 32768;
    localparam int NUM_BLOCKS = 190;

    // Fixed block sequence: descriptors first, then buffers by growing size.
    localparam int SEQ_BLOCKS = 190;
    localparam int PLACED     = (NUM_BLOCKS < SEQ_BLOCKS) ? NUM_BLOCKS : SEQ_BLOCKS;
    localparam int QH_END     = 40;
    localparam int QTD_END    = QH_END + 80;
    localparam int ITD_END    = QTD_END + 20;
    localparam int SITD_END   = ITD_END + 32;
    localparam int B64_END    = SITD_END + 8;
    localparam int B256_END   = B64_END + 4;
    localparam int B512_END   = B256_END + 2;
    localparam int B2K_END    = B512_END + 2;

    localparam int DESC_ALIGN_BITS = 5;
    localparam int PERIODIC_SHIFT  = 2;

    localparam int IDX_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int OFF_W   = $clog2(MEM_BYTES + 16384);
    localparam int SIZE_W  = 13;
    localparam int NCHUNK  = (NUM_BLOCKS + 15) / 16;

    localparam int CFG_W   = 11;
    localparam int DSZ_W   = 9;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_BUILD  = 2'd3;

    localparam logic [2:0] TYPE_QHEAD  = 3'd0;
    localparam logic [2:0] TYPE_QTD    = 3'd1;
    localparam logic [2:0] TYPE_ITD    = 3'd2;
    localparam logic [2:0] TYPE_SITD   = 3'd3;
    localparam logic [2:0] TYPE_BUFFER = 3'd4;
    localparam logic [2:0] TYPE_NONE   = 3'd7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FAIL      = 2'd1;
    localparam logic [1:0] ST_NOT_BUILT = 2'd2;

    localparam logic [2:0] CFG_PERIODIC = 3'd0;
    localparam logic [2:0] CFG_QHEAD    = 3'd1;
    localparam logic [2:0] CFG_QTD      = 3'd2;
    localparam logic [2:0] CFG_ITD      = 3'd3;
    localparam logic [2:0] CFG_SITD     = 3'd4;

    typedef enum logic [1:0] {
        RK_OK,
        RK_FAIL,
        RK_NOT_BUILT,
        RK_BUILD_OK
    } res_kind_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  blk_type;
        logic [15:0] req_size;
        logic [14:0] blk_addr;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  blk_index;
        logic [14:0] blk_offset;
        logic [12:0] blk_bytes;
    } out_item_t;

    typedef struct packed {
        logic      in_load;
        logic      build_start;
        logic      build_step;
        logic      build_done;
        logic      alloc_a;
        logic      alloc_b;
        logic      alloc_c;
        logic      scan_clr;
        logic      rd_en;
        logic      rd_sel_hit;
        logic      out_load;
        res_kind_t res_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       layout_valid;
        logic       build_fail;
        logic       build_last;
        logic       hit_any;
        logic       match;
        logic       scan_last;
        logic       out_free;
    } dp_stat_t;

    function automatic logic [2:0] type_of(input int unsigned i);
        logic [2:0] t;
        if (i >= PLACED)        t = TYPE_NONE;
        else if (i < QH_END)    t = TYPE_QHEAD;
        else if (i < QTD_END)   t = TYPE_QTD;
        else if (i < ITD_END)   t = TYPE_ITD;
        else if (i < SITD_END)  t = TYPE_SITD;
        else                    t = TYPE_BUFFER;
        return t;
    endfunction

    function automatic logic [SIZE_W-1:0] buf_bytes_of(input int unsigned i);
        logic [SIZE_W-1:0] s;
        if (i < B64_END)        s = SIZE_W'(64);
        else if (i < B256_END)  s = SIZE_W'(256);
        else if (i < B512_END)  s = SIZE_W'(512);
        else if (i < B2K_END)   s = SIZE_W'(1024 * 2);
        else                    s = SIZE_W'(1024 * 4);
        return s;
    endfunction

endpackage
`default_nettype wire

>>> rtl/tbpa_ctrl.sv
`default_nettype none
module tbpa_ctrl
    import tbpa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_BUILD_INIT,
        S_BUILD,
        S_ALLOC_A,
        S_ALLOC_B,
        S_ALLOC_C,
        S_ALLOC_D,
        S_SCAN_INIT,
        S_SCAN_PRIME,
        S_SCAN,
        S_RESP
    } state_t;

    state_t    state_reg, state_next;
    res_kind_t kind_reg, kind_next;

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.res_kind = kind_reg;
        s_ready    = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                cmd.in_load = s_valid;
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (stat.op == CMD_BUILD) begin
                    state_next = S_BUILD_INIT;
                end else if (!stat.layout_valid) begin
                    kind_next  = RK_NOT_BUILT;
                    state_next = S_RESP;
                end else if (stat.op == CMD_ALLOC) begin
                    state_next = S_ALLOC_A;
                end else begin
                    state_next = S_SCAN_INIT;
                end
            end
            S_BUILD_INIT: begin
                cmd.build_start = 1'b1;
                state_next      = S_BUILD;
            end
            S_BUILD: begin
                cmd.build_step = 1'b1;
                priority if (stat.build_fail) begin
                    kind_next  = RK_FAIL;
                    state_next = S_RESP;
                end else if (stat.build_last) begin
                    cmd.build_done = 1'b1;
                    kind_next      = RK_BUILD_OK;
                    state_next     = S_RESP;
                end else begin
                    state_next = S_BUILD;
                end
            end
            S_ALLOC_A: begin
                cmd.alloc_a = 1'b1;
                state_next  = S_ALLOC_B;
            end
            S_ALLOC_B: begin
                cmd.alloc_b = 1'b1;
                state_next  = S_ALLOC_C;
            end
            S_ALLOC_C: begin
                cmd.alloc_c = 1'b1;
                state_next  = S_ALLOC_D;
            end
            S_ALLOC_D: begin
                if (stat.hit_any) begin
                    cmd.rd_en      = 1'b1;
                    cmd.rd_sel_hit = 1'b1;
                    kind_next      = RK_OK;
                end else begin
                    kind_next = RK_FAIL;
                end
                state_next = S_RESP;
            end
            S_SCAN_INIT: begin
                cmd.scan_clr = 1'b1;
                state_next   = S_SCAN_PRIME;
            end
            S_SCAN_PRIME: begin
                cmd.rd_en  = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                priority if (stat.match) begin
                    kind_next  = RK_OK;
                    state_next = S_RESP;
                end else if (stat.scan_last) begin
                    kind_next  = RK_FAIL;
                    state_next = S_RESP;
                end else begin
                    cmd.rd_en = 1'b1;
                end
            end
            S_RESP: begin
                cmd.out_load = stat.out_free;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            kind_reg  <= RK_FAIL;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/tbpa_datapath.sv
`default_nettype none
module tbpa_datapath
    import tbpa_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire in_item_t         s_data,
    output out_item_t             m_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire logic             cfg_wr_en,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    input  wire ctrl_cmd_t        cmd,
    output dp_stat_t              stat
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PLACED - 1);
    localparam logic [OFF_W-1:0] MEM_END  = OFF_W'(MEM_BYTES);

    // Configuration registers.
    logic [CFG_W-1:0] periodic_reg;
    logic [DSZ_W-1:0] qh_sz_reg, qtd_sz_reg, itd_sz_reg, sitd_sz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            periodic_reg <= CFG_W'(256);
            qh_sz_reg    <= DSZ_W'(48);
            qtd_sz_reg   <= DSZ_W'(32);
            itd_sz_reg   <= DSZ_W'(64);
            sitd_sz_reg  <= DSZ_W'(28);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PERIODIC: periodic_reg <= cfg_wr_data;
                CFG_QHEAD:    qh_sz_reg    <= cfg_wr_data[DSZ_W-1:0];
                CFG_QTD:      qtd_sz_reg   <= cfg_wr_data[DSZ_W-1:0];
                CFG_ITD:      itd_sz_reg   <= cfg_wr_data[DSZ_W-1:0];
                CFG_SITD:     sitd_sz_reg  <= cfg_wr_data[DSZ_W-1:0];
                default: ;
            endcase
        end
    end

    in_item_t item_reg;

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            item_reg <= s_data;
        end
    end

    // Block offset and size store.
    logic [OFF_W-1:0]  off_mem  [NUM_BLOCKS];
    logic [SIZE_W-1:0] size_mem [NUM_BLOCKS];

    logic [IDX_W-1:0]  bidx_reg;
    logic [OFF_W-1:0]  boff_reg;
    logic              layout_valid_reg;
    logic [NUM_BLOCKS-1:0] marks_reg;

    logic [2:0]        b_type;
    logic [SIZE_W-1:0] b_size;
    logic [OFF_W-1:0]  b_aligned;
    logic [OFF_W-1:0]  b_end;

    always_comb begin
        b_type = type_of(int'(bidx_reg));
        unique case (b_type)
            TYPE_QHEAD:  b_size = SIZE_W'(qh_sz_reg);
            TYPE_QTD:    b_size = SIZE_W'(qtd_sz_reg);
            TYPE_ITD:    b_size = SIZE_W'(itd_sz_reg);
            TYPE_SITD:   b_size = SIZE_W'(sitd_sz_reg);
            default:     b_size = buf_bytes_of(int'(bidx_reg));
        endcase
        if (b_type != TYPE_BUFFER && boff_reg[DESC_ALIGN_BITS-1:0] != '0) begin
            b_aligned = {boff_reg[OFF_W-1:DESC_ALIGN_BITS] + 1'b1,
                         {DESC_ALIGN_BITS{1'b0}}};
        end else begin
            b_aligned = boff_reg;
        end
        b_end = b_aligned + OFF_W'(b_size);
    end

    always_ff @(posedge aclk) begin
        if (cmd.build_start) begin
            bidx_reg <= '0;
            boff_reg <= OFF_W'(periodic_reg) << PERIODIC_SHIFT;
        end else if (cmd.build_step) begin
            bidx_reg <= bidx_reg + 1'b1;
            boff_reg <= b_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.build_step && !(b_end > MEM_END)) begin
            off_mem[bidx_reg]  <= b_aligned;
            size_mem[bidx_reg] <= b_size;
        end
    end

    // Allocation search: candidate vector, per-chunk encode, chunk select.
    logic [NCHUNK*16-1:0] cand_reg;
    logic [NCHUNK*16-1:0] fb_reg;
    logic [NCHUNK*16-1:0] cand_next;
    logic [NCHUNK*16-1:0] fb_next;
    logic [NCHUNK-1:0]    ch_any_reg;
    logic [3:0]           ch_low_reg [NCHUNK];
    logic                 fb_any_reg;
    logic [IDX_W-1:0]     fb_idx_reg;
    logic [NCHUNK-1:0]    ch_any_next;
    logic [3:0]           ch_low_next [NCHUNK];
    logic                 fb_any_next;
    logic [IDX_W-1:0]     fb_idx_next;
    logic                 hit_any_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic                 hit_any_next;
    logic [IDX_W-1:0]     hit_idx_next;

    always_comb begin
        cand_next = '0;
        fb_next   = '0;
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            if (!marks_reg[i] && type_of(i) == item_reg.blk_type) begin
                fb_next[i] = (item_reg.blk_type == TYPE_BUFFER);
                cand_next[i] = (item_reg.blk_type != TYPE_BUFFER) ||
                               ({3'b000, buf_bytes_of(i)} >= item_reg.req_size);
            end
        end
    end

    always_comb begin
        fb_any_next = 1'b0;
        fb_idx_next = '0;
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            if (fb_reg[i]) begin
                fb_any_next = 1'b1;
                fb_idx_next = IDX_W'(i);
            end
        end
        for (int c = 0; c < NCHUNK; c++) begin
            ch_any_next[c] = |cand_reg[c*16 +: 16];
            ch_low_next[c] = '0;
            for (int j = 15; j >= 0; j--) begin
                if (cand_reg[c*16 + j]) begin
                    ch_low_next[c] = 4'(j);
                end
            end
        end
    end

    always_comb begin
        hit_any_next = fb_any_reg;
        hit_idx_next = fb_idx_reg;
        for (int c = NCHUNK - 1; c >= 0; c--) begin
            if (ch_any_reg[c]) begin
                hit_any_next = 1'b1;
                hit_idx_next = IDX_W'(c * 16 + int'(ch_low_reg[c]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.alloc_a) begin
            cand_reg <= cand_next;
            fb_reg   <= fb_next;
        end
        if (cmd.alloc_b) begin
            ch_any_reg <= ch_any_next;
            ch_low_reg <= ch_low_next;
            fb_any_reg <= fb_any_next;
            fb_idx_reg <= fb_idx_next;
        end
        if (cmd.alloc_c) begin
            hit_any_reg <= hit_any_next;
            hit_idx_reg <= hit_idx_next;
        end
    end

    // Store read port, shared by the offset scan and the allocation readout.
    logic [IDX_W-1:0]  scan_idx_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [OFF_W-1:0]  rd_off_reg;
    logic [SIZE_W-1:0] rd_size_reg;

    assign rd_addr = cmd.rd_sel_hit ? hit_idx_reg : scan_idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.scan_clr) begin
            scan_idx_reg <= '0;
        end else if (cmd.rd_en && !cmd.rd_sel_hit && scan_idx_reg != LAST_IDX) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        if (cmd.rd_en) begin
            rd_idx_reg  <= rd_addr;
            rd_off_reg  <= off_mem[rd_addr];
            rd_size_reg <= size_mem[rd_addr];
        end
    end

    // Use marks, layout flag and result register.
    out_item_t res_next;
    out_item_t out_reg;
    logic      m_valid_reg;

    always_comb begin
        res_next = '0;
        unique case (cmd.res_kind)
            RK_OK: begin
                res_next.status     = ST_OK;
                res_next.blk_index  = 8'(rd_idx_reg);
                res_next.blk_offset = rd_off_reg[14:0];
                res_next.blk_bytes  = rd_size_reg;
            end
            RK_FAIL:      res_next.status = ST_FAIL;
            RK_NOT_BUILT: res_next.status = ST_NOT_BUILT;
            RK_BUILD_OK:  res_next.status = ST_OK;
            default:      res_next.status = ST_FAIL;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marks_reg        <= '0;
            layout_valid_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cmd.build_start) begin
                marks_reg        <= '0;
                layout_valid_reg <= 1'b0;
            end else if (cmd.build_done) begin
                layout_valid_reg <= 1'b1;
            end else if (cmd.out_load && cmd.res_kind == RK_OK) begin
                if (item_reg.cmd == CMD_ALLOC) begin
                    marks_reg[rd_idx_reg] <= 1'b1;
                end else if (item_reg.cmd == CMD_FREE) begin
                    marks_reg[rd_idx_reg] <= 1'b0;
                end
            end
            m_valid_reg <= cmd.out_load || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= res_next;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = m_valid_reg;

    always_comb begin
        stat              = '0;
        stat.op           = item_reg.cmd;
        stat.layout_valid = layout_valid_reg;
        stat.build_fail   = b_end > MEM_END;
        stat.build_last   = (bidx_reg == LAST_IDX);
        stat.hit_any      = hit_any_reg;
        stat.match        = (rd_off_reg == OFF_W'(item_reg.blk_addr));
        stat.scan_last    = (rd_idx_reg == LAST_IDX);
        stat.out_free     = !m_valid_reg || m_ready;
    end

endmodule
`default_nettype wire

>>> rtl/typed_block_pool_allocator_core.sv
`default_nettype none
// Channel   Direction  Ports                      Moves
// input     in         s_valid, s_ready, s_data   one command item
// result    out        m_valid, m_ready, m_data   one result item per command
// config    in         cfg_wr_en, cfg_index, ...  one register write per edge
//
// Allocate passes from acceptance to a loaded result through the
// three-stage registered priority search over the use marks plus one store read.
// Free and lookup scan the store, up to 190 blocks, one store entry per cycle.
// Build places the blocks one after another in the fixed sequence.
// Reset clears the use marks and the layout flag at once; no clearing pass runs.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and the block stalls only when a second result finds it still full.
module typed_block_pool_allocator_core
    import tbpa_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_item_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_item_t             m_data,
    input  wire logic             cfg_wr_en,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wr_data
);

    // The controller sequences each command; the datapath holds the store,
    // the use marks, the search logic and the result register.
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    tbpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tbpa_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .m_data      (m_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
`default_nettype wire
